>>> src/mtc_pkg.sv
`timescale 1ns / 1ps
package mtc_pkg;

  // register indexes on the configuration port
  localparam logic CFG_FRAME_RATE = 1'b0;
  localparam logic CFG_OFFSET     = 1'b1;

  localparam int OFFSET_W = 27;

  // MIDI bytes
  localparam logic [7:0] MIDI_SYSEX     = 8'hF0;
  localparam logic [7:0] MIDI_REALTIME  = 8'h7F;
  localparam logic [7:0] MIDI_MTC_ID    = 8'h01;
  localparam logic [7:0] MIDI_QFRAME    = 8'hF1;
  localparam logic [7:0] MIDI_EOX       = 8'hF7;
  localparam logic [7:0] MIDI_CLOCK     = 8'hF8;
  localparam logic [7:0] MIDI_START     = 8'hFA;
  localparam logic [7:0] MIDI_STOP      = 8'hFC;

  // frame rate codes
  localparam logic [1:0] RATE_24   = 2'd0;
  localparam logic [1:0] RATE_25   = 2'd1;
  localparam logic [1:0] RATE_2997 = 2'd2;

  // quotients by multiply and shift: the divisor's power of two is shifted
  // off the dividend first, and each reciprocal is exact over its range
  localparam logic [14:0] HOUR_K     = 15'd28125;     // 3600000 >> 7
  localparam logic [25:0] HOUR_RECIP = 26'd39093747;  // ceil(2^40 / 28125)
  localparam logic [10:0] MIN_K      = 11'd1875;      // 60000 >> 5
  localparam logic [17:0] MIN_RECIP  = 18'd143166;    // ceil(2^28 / 1875)
  localparam logic [6:0]  SEC_K      = 7'd125;        // 1000 >> 3
  localparam logic [13:0] SEC_RECIP  = 14'd8389;      // ceil(2^20 / 125)
  localparam logic [17:0] FRM_RECIP  = 18'd171799;    // ceil(2^29 / 3125), 100000 >> 5

  typedef enum logic [2:0] {
    K_STOP,
    K_START,
    K_FULL,
    K_QLO,
    K_QHI
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [32:0] t;
  } conv_req_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] hour;
    logic [5:0] mins;
    logic [5:0] secs;
    logic [4:0] frames;
  } mtc_rec_t;

  function automatic logic [11:0] frame_mul(input logic [1:0] rate);
    case (rate)
      RATE_24:   frame_mul = 12'd24;
      RATE_25:   frame_mul = 12'd25;
      RATE_2997: frame_mul = 12'd2997;
      default:   frame_mul = 12'd30;
    endcase
  endfunction

endpackage

>>> src/mtc_if.sv
`timescale 1ns / 1ps
interface mtc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] position_ms;

  modport source(output valid, req_type, position_ms, input ready);
  modport sink(input valid, req_type, position_ms, output ready);
endinterface

interface mtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       last_byte;

  modport source(output valid, midi_byte, last_byte, input ready);
  modport sink(input valid, midi_byte, last_byte, output ready);
endinterface

>>> src/mtc_front.sv
`timescale 1ns / 1ps
module mtc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  mtc_in_if.sink                            in_ch,
  input  logic [mtc_pkg::OFFSET_W-1:0]      offset,
  output mtc_pkg::conv_req_t                req,
  output logic                              req_valid,
  input  logic                              req_ready
);

  logic               running_r;
  logic               upper_r;
  logic [31:0]        last_r;
  logic               hold_valid_r;
  mtc_pkg::conv_req_t hold_r;

  logic               acc;
  logic               take;
  logic               emit;
  logic [32:0]        diff;
  logic               jump;
  mtc_pkg::kind_t     kind;

  assign take        = hold_valid_r && req_ready;
  assign in_ch.ready = !hold_valid_r || req_ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign emit        = acc && (!in_ch.req_type || running_r);
  assign req         = hold_r;
  assign req_valid   = hold_valid_r;

  assign diff = {1'b0, in_ch.position_ms} - {1'b0, last_r};
  assign jump = diff[32] || (diff[31:0] > 32'd1000);

  always_comb begin
    if (in_ch.req_type) begin
      kind = mtc_pkg::K_STOP;
    end else if (!running_r) begin
      kind = mtc_pkg::K_START;
    end else if (jump) begin
      kind = mtc_pkg::K_FULL;
    end else if (upper_r) begin
      kind = mtc_pkg::K_QHI;
    end else begin
      kind = mtc_pkg::K_QLO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      upper_r      <= 1'b0;
      last_r       <= '0;
      hold_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        hold_valid_r <= 1'b1;
      end else if (take) begin
        hold_valid_r <= 1'b0;
      end
      if (acc) begin
        if (in_ch.req_type) begin
          running_r <= 1'b0;
        end else begin
          running_r <= 1'b1;
          last_r    <= in_ch.position_ms;
          upper_r   <= (kind == mtc_pkg::K_QLO);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold_r.kind <= kind;
      hold_r.t    <= {1'b0, in_ch.position_ms} + {6'b0, offset};
    end
  end

  a_pos_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_ch.req_type) |=> (running_r && hold_valid_r))
    else $error("position word did not start playback");

  a_stop_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.req_type) |=> !running_r)
    else $error("stop word left block running");

endmodule

>>> src/mtc_conv.sv
`timescale 1ns / 1ps
module mtc_conv (
  input  logic               clk,
  input  logic               rst_n,
  input  mtc_pkg::conv_req_t req,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         rate,
  output mtc_pkg::mtc_rec_t  rec,
  output logic               rec_valid,
  input  logic               rec_ready
);

  typedef enum logic [3:0] {
    C_IDLE,
    C_HOUR_Q,
    C_HOUR_R,
    C_MIN_Q,
    C_MIN_R,
    C_SEC_Q,
    C_SEC_R,
    C_FRM_MUL,
    C_FRM_Q,
    C_PUSH
  } cstate_t;

  cstate_t        state_r;
  logic [32:0]    val_r;
  logic [10:0]    hq_r;
  mtc_pkg::kind_t kind_r;
  logic [4:0]     hour_r;
  logic [5:0]     mins_r;
  logic [5:0]     secs_r;
  logic [4:0]     frames_r;

  logic [51:0]    hour_prod;
  logic [25:0]    hour_left;
  logic [34:0]    min_prod;
  logic [16:0]    min_left;
  logic [26:0]    sec_prod;
  logic [12:0]    sec_left;
  logic [21:0]    frm_prod;
  logic [34:0]    frm_quot;

  // quotient by reciprocal multiply, then remainder by multiply and subtract
  assign hour_prod = {26'b0, val_r[32:7]} * {26'b0, mtc_pkg::HOUR_RECIP};
  assign hour_left = val_r[32:7] - ({15'b0, hq_r} * {11'b0, mtc_pkg::HOUR_K});
  assign min_prod  = {18'b0, val_r[21:5]} * {17'b0, mtc_pkg::MIN_RECIP};
  assign min_left  = val_r[21:5] - ({11'b0, mins_r} * {6'b0, mtc_pkg::MIN_K});
  assign sec_prod  = {14'b0, val_r[15:3]} * {13'b0, mtc_pkg::SEC_RECIP};
  assign sec_left  = val_r[15:3] - ({7'b0, secs_r} * {6'b0, mtc_pkg::SEC_K});
  assign frm_prod  = {12'b0, val_r[9:0]} * {10'b0, mtc_pkg::frame_mul(rate)};
  assign frm_quot  = {18'b0, val_r[21:5]} * {17'b0, mtc_pkg::FRM_RECIP};

  assign req_ready  = (state_r == C_IDLE);
  assign rec_valid  = (state_r == C_PUSH);
  assign rec.kind   = kind_r;
  assign rec.hour   = hour_r;
  assign rec.mins   = mins_r;
  assign rec.secs   = secs_r;
  assign rec.frames = frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (req_valid) begin
            kind_r  <= req.kind;
            val_r   <= req.t;
            state_r <= (req.kind == mtc_pkg::K_STOP) ? C_PUSH : C_HOUR_Q;
          end
        end
        C_HOUR_Q: begin
          hq_r    <= hour_prod[50:40];
          state_r <= C_HOUR_R;
        end
        C_HOUR_R: begin
          hour_r  <= hq_r[4:0];
          val_r   <= {11'b0, hour_left[14:0], val_r[6:0]};
          state_r <= C_MIN_Q;
        end
        C_MIN_Q: begin
          mins_r  <= min_prod[33:28];
          state_r <= C_MIN_R;
        end
        C_MIN_R: begin
          val_r   <= {17'b0, min_left[10:0], val_r[4:0]};
          state_r <= C_SEC_Q;
        end
        C_SEC_Q: begin
          secs_r  <= sec_prod[25:20];
          state_r <= C_SEC_R;
        end
        C_SEC_R: begin
          val_r   <= {23'b0, sec_left[6:0], val_r[2:0]};
          state_r <= C_FRM_MUL;
        end
        C_FRM_MUL: begin
          val_r   <= {11'b0, frm_prod};
          state_r <= C_FRM_Q;
        end
        C_FRM_Q: begin
          // integer rates divide by 1000, the same step as seconds
          frames_r <= (rate == mtc_pkg::RATE_2997) ? frm_quot[33:29] : sec_prod[24:20];
          state_r  <= C_PUSH;
        end
        C_PUSH: begin
          if (rec_ready) begin
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule

>>> src/mtc_fifo.sv
`timescale 1ns / 1ps
module mtc_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mtc_pkg::mtc_rec_t push_data,
  input  logic              push_valid,
  output logic              push_ready,
  output mtc_pkg::mtc_rec_t pop_data,
  output logic              pop_valid,
  input  logic              pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mtc_pkg::mtc_rec_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  logic push;
  logic pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue count lost a push");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("queue count lost a pop");

endmodule

>>> src/mtc_back.sv
`timescale 1ns / 1ps
module mtc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mtc_pkg::mtc_rec_t rec,
  input  logic              rec_valid,
  output logic              rec_ready,
  input  logic [1:0]        rate,
  mtc_out_if.source         out_ch
);

  mtc_pkg::mtc_rec_t cur_r;
  logic              cur_valid_r;
  logic [3:0]        idx_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;

  logic              load;
  logic              is_last;
  logic [3:0]        lenm1;
  logic [7:0]        byte_val;

  function automatic logic [7:0] full_byte(input mtc_pkg::mtc_rec_t r,
                                           input logic [1:0] rc,
                                           input logic [3:0] j);
    case (j)
      4'd0:    full_byte = mtc_pkg::MIDI_SYSEX;
      4'd1:    full_byte = mtc_pkg::MIDI_REALTIME;
      4'd2:    full_byte = mtc_pkg::MIDI_REALTIME;
      4'd3:    full_byte = mtc_pkg::MIDI_MTC_ID;
      4'd4:    full_byte = mtc_pkg::MIDI_MTC_ID;
      4'd5:    full_byte = {1'b0, rc, r.hour};
      4'd6:    full_byte = {2'b0, r.mins};
      4'd7:    full_byte = {2'b0, r.secs};
      4'd8:    full_byte = {3'b0, r.frames};
      default: full_byte = mtc_pkg::MIDI_EOX;
    endcase
  endfunction

  function automatic logic [7:0] quarter_byte(input mtc_pkg::mtc_rec_t r,
                                              input logic [1:0] rc,
                                              input logic [3:0] j);
    logic [2:0] slot;
    logic [3:0] nib;
    slot = {(r.kind == mtc_pkg::K_QHI), j[2:1]};
    case (slot)
      3'd0:    nib = r.frames[3:0];
      3'd1:    nib = {3'b0, r.frames[4]};
      3'd2:    nib = r.secs[3:0];
      3'd3:    nib = {2'b0, r.secs[5:4]};
      3'd4:    nib = r.mins[3:0];
      3'd5:    nib = {2'b0, r.mins[5:4]};
      3'd6:    nib = r.hour[3:0];
      default: nib = {1'b0, rc, r.hour[4]};
    endcase
    if (j == 4'd8) begin
      quarter_byte = mtc_pkg::MIDI_CLOCK;
    end else if (!j[0]) begin
      quarter_byte = mtc_pkg::MIDI_QFRAME;
    end else begin
      quarter_byte = {1'b0, slot, nib};
    end
  endfunction

  always_comb begin
    case (cur_r.kind)
      mtc_pkg::K_STOP: begin
        lenm1    = 4'd0;
        byte_val = mtc_pkg::MIDI_STOP;
      end
      mtc_pkg::K_START: begin
        lenm1    = 4'd10;
        byte_val = (idx_r == 4'd0) ? mtc_pkg::MIDI_START
                                   : full_byte(cur_r, rate, idx_r - 1'b1);
      end
      mtc_pkg::K_FULL: begin
        lenm1    = 4'd9;
        byte_val = full_byte(cur_r, rate, idx_r);
      end
      default: begin
        lenm1    = 4'd8;
        byte_val = quarter_byte(cur_r, rate, idx_r);
      end
    endcase
  end

  assign is_last          = (idx_r == lenm1);
  assign load             = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign rec_ready        = !cur_valid_r || (load && is_last);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.midi_byte = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rec_valid && rec_ready) begin
        cur_valid_r <= 1'b1;
      end else if (load && is_last) begin
        cur_valid_r <= 1'b0;
      end
      if (load) begin
        idx_r       <= is_last ? 4'd0 : idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      cur_r <= rec;
    end
    if (load) begin
      out_byte_r <= byte_val;
      out_last_r <= is_last;
    end
  end

  a_seq_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (load && is_last) |=> (idx_r == 4'd0 && out_last_r))
    else $error("byte index not rewound after last word");

endmodule

>>> src/midi_timecode_generator_top.sv
`timescale 1ns / 1ps
// MIDI Timecode generator.
// in_ch: one word per request, req_type 0 = position in ms, 1 = stop.
// out_ch: one MIDI byte per word, last_byte marks the final byte of a request.
// cfg_we/cfg_index/cfg_wdata: index 0 frame rate code, index 1 offset in ms;
// write only while nothing is in flight.
// A position word gives FA plus a full-frame SysEx after reset or a stop,
// a full frame on a backward jump or a jump of more than 1000 ms, and
// otherwise four quarter-frame pairs and F8. A running stop gives FC; an idle
// stop gives nothing.
// The timecode converter takes a new request only once done with the last and
// works it out in steps (hours, minutes and seconds each by a reciprocal
// multiply and a remainder step, then the frame multiply and divide); a stop
// word skips these steps. Bytes leave at one per cycle while out_ch is ready.
// A holding register takes the next word while the converter is busy, and a
// small queue lets conversion run ahead while the receiver stalls; out_ch
// holds its word until taken.
// Reset: idle, lower half first, rate 24 fps, zero offset, all queues empty.
module midi_timecode_generator_top #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  mtc_in_if.sink                       in_ch,
  mtc_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [mtc_pkg::OFFSET_W-1:0] cfg_wdata
);

  logic [1:0]                   rate_r;
  logic [mtc_pkg::OFFSET_W-1:0] offset_r;

  mtc_pkg::conv_req_t req;
  logic               req_valid;
  logic               req_ready;
  mtc_pkg::mtc_rec_t  conv_rec;
  logic               conv_valid;
  logic               conv_ready;
  mtc_pkg::mtc_rec_t  q_rec;
  logic               q_valid;
  logic               q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= '0;
      offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mtc_pkg::CFG_FRAME_RATE: rate_r   <= cfg_wdata[1:0];
        mtc_pkg::CFG_OFFSET:     offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mtc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .offset    (offset_r),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready)
  );

  mtc_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rate      (rate_r),
    .rec       (conv_rec),
    .rec_valid (conv_valid),
    .rec_ready (conv_ready)
  );

  mtc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (conv_rec),
    .push_valid (conv_valid),
    .push_ready (conv_ready),
    .pop_data   (q_rec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  mtc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (q_rec),
    .rec_valid (q_valid),
    .rec_ready (q_ready),
    .rate      (rate_r),
    .out_ch    (out_ch)
  );

endmodule
